[hdl/hcl2rgb_pkg.sv]
// Shared types and constants for the hue/chroma/luma to RGB converter.
// Used by every module of the converter; depends on nothing.
`default_nettype none

package hcl2rgb_pkg;

   // Hue layout: 256 units per 60-degree sector, six sectors per circle.
   localparam int unsigned HUE_W        = 11;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned CODE_W       = 8;
   localparam int unsigned PROV_W       = 16;
   localparam int unsigned LUMA_SUM_W   = 32;

   localparam logic [HUE_W-1:0] HUE_FULL_CIRCLE = 11'd1536;

   // Rec.601 luma weights in Q0.16; they add up to exactly 1.0.
   localparam logic [15:0] WEIGHT_RED   = 16'd19595;
   localparam logic [15:0] WEIGHT_GREEN = 16'd38470;
   localparam logic [15:0] WEIGHT_BLUE  = 16'd7471;

   // Provisional color, in units of 1/(255*256), plus the target luma.
   typedef struct packed {
      logic [PROV_W-1:0] pr;
      logic [PROV_W-1:0] pg;
      logic [PROV_W-1:0] pb;
      logic [CODE_W-1:0] luma;
   } prov_type;

   // Provisional color with its luma, in units of 1/(255*2^24).
   typedef struct packed {
      prov_type              prov;
      logic [LUMA_SUM_W-1:0] prov_luma;
   } prov_luma_type;

   // Load enables of the two register stages in the luma unit.
   typedef struct packed {
      logic prod_load;
      logic sum_load;
   } weight_ctl_type;

endpackage

`default_nettype wire

[hdl/hcl2rgb_sector.sv]
// First pipeline stage: hue wrap, sector decode and provisional color.
// Depends on hcl2rgb_pkg.
`default_nettype none

module hcl2rgb_sector
   import hcl2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [HUE_W-1:0]  hue,
   input  wire logic [CODE_W-1:0] chroma,
   input  wire logic [CODE_W-1:0] luma,
   output      prov_type          prov
);

   // Sector codes, named after the hue span they cover.
   localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;

   logic [HUE_W-1:0]  hue_wrap;
   logic [2:0]        sector;
   logic [POS_W-1:0]  pos;
   logic [POS_W:0]    ramp;
   logic [PROV_W:0]   secondary_full;
   logic [PROV_W-1:0] big;
   logic [PROV_W-1:0] secondary;
   prov_type          prov_in;
   prov_type          prov_ff;

   always_comb begin
      hue_wrap   = (hue >= HUE_FULL_CIRCLE) ? hue - HUE_FULL_CIRCLE : hue;
      sector     = hue_wrap[HUE_W-1:POS_W];
      pos        = hue_wrap[POS_W-1:0];
      // Odd sectors ramp down, even sectors ramp up.
      ramp       = sector[0] ? ((POS_W+1)'(1 << POS_W) - {1'b0, pos}) : {1'b0, pos};
      secondary_full = {{(PROV_W+1-CODE_W){1'b0}}, chroma}
                     * {{(PROV_W-POS_W){1'b0}}, ramp};
      // chroma * 256 at most is 65280, so 16 bits always suffice.
      secondary  = secondary_full[PROV_W-1:0];
      big        = {chroma, {POS_W{1'b0}}};

      prov_in.pr   = '0;
      prov_in.pg   = '0;
      prov_in.pb   = '0;
      prov_in.luma = luma;
      unique case (sector)
         SECTOR_RED_YELLOW: begin
            prov_in.pr = big;
            prov_in.pg = secondary;
         end
         SECTOR_YELLOW_GREEN: begin
            prov_in.pr = secondary;
            prov_in.pg = big;
         end
         SECTOR_GREEN_CYAN: begin
            prov_in.pg = big;
            prov_in.pb = secondary;
         end
         SECTOR_CYAN_BLUE: begin
            prov_in.pg = secondary;
            prov_in.pb = big;
         end
         SECTOR_BLUE_MAGENTA: begin
            prov_in.pb = big;
            prov_in.pr = secondary;
         end
         default: begin
            prov_in.pb = secondary;
            prov_in.pr = big;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prov_ff <= prov_in;
      end
   end

   assign prov = prov_ff;

endmodule

`default_nettype wire

[hdl/hcl2rgb_weight.sv]
// Second and third pipeline stages: weighted products, then the luma sum.
// Depends on hcl2rgb_pkg.
`default_nettype none

module hcl2rgb_weight
   import hcl2rgb_pkg::*;
(
   input  wire logic           clock,
   input  wire weight_ctl_type ctl,
   input  wire prov_type       prov,
   output prov_luma_type       prov_luma
);

   logic [LUMA_SUM_W-1:0] prod_r_in;
   logic [LUMA_SUM_W-1:0] prod_g_in;
   logic [LUMA_SUM_W-1:0] prod_b_in;
   logic [LUMA_SUM_W-1:0] prod_r_ff;
   logic [LUMA_SUM_W-1:0] prod_g_ff;
   logic [LUMA_SUM_W-1:0] prod_b_ff;
   prov_type              prov_ff;
   logic [LUMA_SUM_W:0]   sum_full;
   prov_luma_type         prov_luma_in;
   prov_luma_type         prov_luma_ff;

   always_comb begin
      prod_r_in = LUMA_SUM_W'(WEIGHT_RED)   * LUMA_SUM_W'(prov.pr);
      prod_g_in = LUMA_SUM_W'(WEIGHT_GREEN) * LUMA_SUM_W'(prov.pg);
      prod_b_in = LUMA_SUM_W'(WEIGHT_BLUE)  * LUMA_SUM_W'(prov.pb);
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_load) begin
         prod_r_ff <= prod_r_in;
         prod_g_ff <= prod_g_in;
         prod_b_ff <= prod_b_in;
         prov_ff   <= prov;
      end
   end

   // The weights add up to 1.0 and each channel is at most 1.0, so the
   // luma sum never leaves 32 bits.
   always_comb begin
      sum_full = {1'b0, prod_r_ff} + {1'b0, prod_g_ff} + {1'b0, prod_b_ff};
      prov_luma_in.prov      = prov_ff;
      prov_luma_in.prov_luma = sum_full[LUMA_SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_load) begin
         prov_luma_ff <= prov_luma_in;
      end
   end

   assign prov_luma = prov_luma_ff;

endmodule

`default_nettype wire

[hdl/hcl2rgb_clamp.sv]
// Last pipeline stage: luma offset, clamp to 0..1.0 and round to 8 bits.
// Depends on hcl2rgb_pkg.
`default_nettype none

module hcl2rgb_clamp
   import hcl2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire prov_luma_type     prov_luma,
   output logic [CODE_W-1:0]      red,
   output logic [CODE_W-1:0]      green,
   output logic [CODE_W-1:0]      blue
);

   localparam int unsigned S_W = 35;
   localparam logic signed [S_W-1:0] S_TOP = 35'sd255 <<< 24;

   // S = P*2^16 + luma*2^24 - L, clamped to 0..255*2^24, then rounded.
   function automatic logic [CODE_W-1:0] channel_code(
      input logic [PROV_W-1:0]     p,
      input logic [CODE_W-1:0]     luma,
      input logic [LUMA_SUM_W-1:0] lsum
   );
      logic signed [S_W-1:0] s;
      logic [31:0]           rounded;
      logic [CODE_W-1:0]     code;
      s = $signed({3'b000, p, 16'h0000})
        + $signed({3'b000, luma, 24'h000000})
        - $signed({3'b000, lsum});
      rounded = s[31:0] + 32'h0080_0000;
      if (s[S_W-1]) begin
         code = '0;
      end else if (s > S_TOP) begin
         code = '1;
      end else begin
         code = rounded[31:24];
      end
      return code;
   endfunction

   logic [CODE_W-1:0] red_in;
   logic [CODE_W-1:0] green_in;
   logic [CODE_W-1:0] blue_in;
   logic [CODE_W-1:0] red_ff;
   logic [CODE_W-1:0] green_ff;
   logic [CODE_W-1:0] blue_ff;

   always_comb begin
      red_in   = channel_code(prov_luma.prov.pr, prov_luma.prov.luma, prov_luma.prov_luma);
      green_in = channel_code(prov_luma.prov.pg, prov_luma.prov.luma, prov_luma.prov_luma);
      blue_in  = channel_code(prov_luma.prov.pb, prov_luma.prov.luma, prov_luma.prov_luma);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

`default_nettype wire

[hdl/hcl_to_rgb_converter_unit.sv]
// Each accepted request beat passes the four register stages (sector decode,
// weight products, luma sum, clamp and round) in order to its response beat.
// Throughput: one pixel per cycle through every stage while rsp_stall is low.
// A stalled response holds only the stages that are occupied; bubbles close up.
// Reset (synchronous, active high) clears the stage valid bits only.
// Top level of the converter; depends on hcl2rgb_pkg and the stage modules.
`default_nettype none

module hcl_to_rgb_converter_unit
   import hcl2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [HUE_W-1:0]  req_hue,
   input  wire logic [CODE_W-1:0] req_chroma,
   input  wire logic [CODE_W-1:0] req_luma,

   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [CODE_W-1:0] rsp_red,
   output      logic [CODE_W-1:0] rsp_green,
   output      logic [CODE_W-1:0] rsp_blue
);

   // One valid bit per register stage. Stage four is the response register.
   logic sector_valid_ff;
   logic sector_valid_in;
   logic prod_valid_ff;
   logic prod_valid_in;
   logic sum_valid_ff;
   logic sum_valid_in;
   logic out_valid_ff;
   logic out_valid_in;

   // A stage loads when it is empty or when the stage after it loads too.
   // This lets a bubble anywhere in the pipe be filled while the output is
   // stalled, and a full pipe under stall pushes back on the request side.
   logic sector_load;
   logic prod_load;
   logic sum_load;
   logic out_load;

   prov_type       prov;
   prov_luma_type  prov_luma;
   weight_ctl_type weight_ctl;

   always_comb begin
      out_load    = !out_valid_ff || !rsp_stall;
      sum_load    = !sum_valid_ff || out_load;
      prod_load   = !prod_valid_ff || sum_load;
      sector_load = !sector_valid_ff || prod_load;

      sector_valid_in = sector_load ? req_valid       : sector_valid_ff;
      prod_valid_in   = prod_load   ? sector_valid_ff : prod_valid_ff;
      sum_valid_in    = sum_load    ? prod_valid_ff   : sum_valid_ff;
      out_valid_in    = out_load    ? sum_valid_ff    : out_valid_ff;

      weight_ctl.prod_load = prod_load;
      weight_ctl.sum_load  = sum_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_valid_ff <= 1'b0;
         prod_valid_ff   <= 1'b0;
         sum_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         sector_valid_ff <= sector_valid_in;
         prod_valid_ff   <= prod_valid_in;
         sum_valid_ff    <= sum_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   assign req_stall = !sector_load;
   assign rsp_valid = out_valid_ff;

   // Stage one: wrap the hue, pick the sector, place chroma and x.
   hcl2rgb_sector u_sector (
      .clock  (clock),
      .load   (sector_load),
      .hue    (req_hue),
      .chroma (req_chroma),
      .luma   (req_luma),
      .prov   (prov)
   );

   // Stages two and three: weighted products, then the provisional luma.
   hcl2rgb_weight u_weight (
      .clock     (clock),
      .ctl       (weight_ctl),
      .prov      (prov),
      .prov_luma (prov_luma)
   );

   // Stage four: add the luma offset, clamp and round each channel.
   hcl2rgb_clamp u_clamp (
      .clock     (clock),
      .load      (out_load),
      .prov_luma (prov_luma),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

   // An accepted request beat always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> sector_valid_ff)
      else $error("accepted request beat did not enter the first stage");

   // With the response side free, every stage can advance, so no back-pressure.
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while the response side is free");

   // A full pipe with a stalled response must push back on the request side.
   a_full_pushes_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_stall && sector_valid_ff && prod_valid_ff && sum_valid_ff && out_valid_ff)
      |-> req_stall)
      else $error("full pipeline failed to stall the request side");

   // A stalled response keeps the stage behind it occupied.
   a_stall_holds_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && sum_valid_ff) |=> sum_valid_ff)
      else $error("stage three lost its beat during a response stall");

endmodule

`default_nettype wire

[sim/hcl_to_rgb_converter_checker.sv]
// Checker for the hue/chroma/luma to RGB converter: predicts each pixel and compares responses.
// Watches the request and response channels; depends on hcl2rgb_pkg for widths and weights.
`timescale 1ns / 1ps

module hcl_to_rgb_converter_checker
   import hcl2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [HUE_W-1:0]  req_hue,
   input  wire logic [CODE_W-1:0] req_chroma,
   input  wire logic [CODE_W-1:0] req_luma,

   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [CODE_W-1:0] rsp_red,
   input  wire logic [CODE_W-1:0] rsp_green,
   input  wire logic [CODE_W-1:0] rsp_blue,

   output int                     mismatch_count,
   output int                     pixels_pending,
   output int                     pixels_checked
);

   typedef struct {
      logic [CODE_W-1:0] red;
      logic [CODE_W-1:0] green;
      logic [CODE_W-1:0] blue;
   } rgb_code_type;

   // Sectors of the hue circle, named by the colors they run between.
   typedef enum int {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } hue_sector_type;

   rgb_code_type expected_pixels[$];

   // Clamp a channel (units of 1/(255*2^24)) to 0..1.0 and round half up.
   function automatic logic [CODE_W-1:0] round_channel(input longint scaled);
      longint top_value;
      longint clamped;
      top_value = longint'(255) <<< 24;
      clamped = scaled;
      if (clamped < 0)
         clamped = 0;
      else if (clamped > top_value)
         clamped = top_value;
      return CODE_W'((clamped + (longint'(1) <<< 23)) >>> 24);
   endfunction

   function automatic rgb_code_type predict_rgb(input logic [HUE_W-1:0] hue,
                                                input logic [CODE_W-1:0] chroma,
                                                input logic [CODE_W-1:0] luma);
      logic [HUE_W-1:0] hue_wrapped;
      hue_sector_type sector;
      longint ramp;
      longint chroma_l;
      longint luma_l;
      longint big;
      longint small_part;
      longint pr;
      longint pg;
      longint pb;
      longint prov_luma;
      longint offset;
      rgb_code_type pixel;
      hue_wrapped = hue;
      // Hues past the full circle wrap around once.
      if (hue_wrapped >= HUE_FULL_CIRCLE)
         hue_wrapped = hue_wrapped - HUE_FULL_CIRCLE;
      sector = hue_sector_type'(int'(hue_wrapped[HUE_W-1:POS_W]));
      ramp = longint'(hue_wrapped[POS_W-1:0]);
      if (hue_wrapped[POS_W])
         ramp = 256 - ramp;
      chroma_l = longint'(chroma);
      luma_l = longint'(luma);
      big = chroma_l * 256;
      small_part = chroma_l * ramp;
      pr = 0;
      pg = 0;
      pb = 0;
      case (sector)
         SECTOR_RED_YELLOW: begin
            pr = big;
            pg = small_part;
         end
         SECTOR_YELLOW_GREEN: begin
            pr = small_part;
            pg = big;
         end
         SECTOR_GREEN_CYAN: begin
            pg = big;
            pb = small_part;
         end
         SECTOR_CYAN_BLUE: begin
            pg = small_part;
            pb = big;
         end
         SECTOR_BLUE_MAGENTA: begin
            pb = big;
            pr = small_part;
         end
         default: begin
            pb = small_part;
            pr = big;
         end
      endcase
      prov_luma = longint'(WEIGHT_RED) * pr + longint'(WEIGHT_GREEN) * pg
                + longint'(WEIGHT_BLUE) * pb;
      offset = (luma_l <<< 24) - prov_luma;
      pixel.red   = round_channel(pr * 65536 + offset);
      pixel.green = round_channel(pg * 65536 + offset);
      pixel.blue  = round_channel(pb * 65536 + offset);
      return pixel;
   endfunction

   task automatic compare_channel(input string channel, input logic [CODE_W-1:0] expected,
                                  input logic [CODE_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, actual %0d", channel, expected, actual);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      pixels_pending = 0;
      pixels_checked = 0;
   end

   always @(posedge clock) begin
      rgb_code_type oldest;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_pixels.push_back(predict_rgb(req_hue, req_chroma, req_luma));
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("response beat with no pixel outstanding: %0d %0d %0d",
                      rsp_red, rsp_green, rsp_blue);
               mismatch_count++;
            end else begin
               oldest = expected_pixels.pop_front();
               compare_channel("red", oldest.red, rsp_red);
               compare_channel("green", oldest.green, rsp_green);
               compare_channel("blue", oldest.blue, rsp_blue);
               pixels_checked++;
            end
         end
         pixels_pending = expected_pixels.size();
      end
   end

endmodule

[sim/hcl_to_rgb_converter_unit_tb.sv]
// Testbench top for the hue/chroma/luma to RGB converter: clock, reset, stimulus and verdict.
// Depends on hcl2rgb_pkg, hcl_to_rgb_converter_unit and hcl_to_rgb_converter_checker.
`timescale 1ns / 1ps

module hcl_to_rgb_converter_unit_tb;
   import hcl2rgb_pkg::*;

   // This bound is far above what the slowest correct run needs.
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PIXELS_PER_PHASE = 370;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [HUE_W-1:0]  req_hue;
   logic [CODE_W-1:0] req_chroma;
   logic [CODE_W-1:0] req_luma;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [CODE_W-1:0] rsp_red;
   logic [CODE_W-1:0] rsp_green;
   logic [CODE_W-1:0] rsp_blue;

   int mismatch_count;
   int pixels_pending;
   int pixels_checked;
   int cycle_count = 0;

   // Percentages of cycles in which the sender holds back a beat and the
   // receiver stalls. They change from phase to phase.
   int send_idle_pct;
   int recv_stall_pct;

   // Free-running clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   hcl_to_rgb_converter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_hue    (req_hue),
      .req_chroma (req_chroma),
      .req_luma   (req_luma),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue)
   );

   // The checker sees exactly what the converter sees and keeps the score.
   hcl_to_rgb_converter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_chroma     (req_chroma),
      .req_luma       (req_luma),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .mismatch_count (mismatch_count),
      .pixels_pending (pixels_pending),
      .pixels_checked (pixels_checked)
   );

   // The receiver decides anew at every falling edge whether to stall the
   // response channel. Stall may depend on anything; valid never looks at it.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one pixel on the request channel and hold it until it is taken.
   // The task is entered and left at a falling edge. When the sender idles,
   // valid drops for whole cycles; when it does not, valid simply stays high
   // so that beats go back to back.
   task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CODE_W-1:0] chroma,
                             input logic [CODE_W-1:0] luma);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_hue    <= hue;
      req_chroma <= chroma;
      req_luma   <= luma;
      // The beat is taken at the first rising edge with stall low.
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // Random pixels with random content. Hues past the full circle and the
   // extreme chroma and luma codes get extra weight, since they hit the wrap
   // and the clamps.
   task automatic send_random_pixels(input int count);
      logic [HUE_W-1:0]  hue;
      logic [CODE_W-1:0] chroma;
      logic [CODE_W-1:0] luma;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(7) == 0)
            hue = HUE_W'($urandom_range(2047, 1536));
         else
            hue = HUE_W'($urandom_range(1535));
         if ($urandom_range(7) == 0)
            chroma = $urandom_range(1) ? 8'hFF : 8'h00;
         else
            chroma = CODE_W'($urandom_range(255));
         if ($urandom_range(7) == 0)
            luma = $urandom_range(1) ? 8'hFF : 8'h00;
         else
            luma = CODE_W'($urandom_range(255));
         send_pixel(hue, chroma, luma);
      end
   endtask

   // The sender goes quiet until every outstanding pixel has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pixels_pending != 0)
         @(negedge clock);
   endtask

   initial begin
      // Every input starts at a known value, with reset held.
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_hue        = '0;
      req_chroma     = '0;
      req_luma       = '0;
      rsp_stall      = 1'b0;
      send_idle_pct  = 18;
      recv_stall_pct = 55;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pixels. The first and last hue of each sector, with full
      // chroma, show the placement of the primary and secondary components.
      send_pixel(11'd0,    8'd255, 8'd128);
      send_pixel(11'd255,  8'd255, 8'd128);
      send_pixel(11'd256,  8'd255, 8'd128);
      send_pixel(11'd511,  8'd255, 8'd128);
      send_pixel(11'd512,  8'd255, 8'd128);
      send_pixel(11'd767,  8'd255, 8'd128);
      send_pixel(11'd768,  8'd255, 8'd128);
      send_pixel(11'd1023, 8'd255, 8'd128);
      send_pixel(11'd1024, 8'd255, 8'd128);
      send_pixel(11'd1279, 8'd255, 8'd128);
      send_pixel(11'd1280, 8'd255, 8'd128);
      send_pixel(11'd1535, 8'd255, 8'd128);
      // Hues past the full circle wrap back into the first two sectors.
      send_pixel(11'd1536, 8'd200, 8'd100);
      send_pixel(11'd1791, 8'd200, 8'd100);
      send_pixel(11'd2047, 8'd200, 8'd100);
      // Zero chroma is pure gray at the target luma.
      send_pixel(11'd0,    8'd0,   8'd0);
      send_pixel(11'd700,  8'd0,   8'd255);
      send_pixel(11'd1200, 8'd0,   8'd77);
      // Saturated colors at dark and bright targets drive the channels into
      // both clamps.
      send_pixel(11'd0,    8'd255, 8'd0);
      send_pixel(11'd0,    8'd255, 8'd255);
      send_pixel(11'd512,  8'd255, 8'd255);
      send_pixel(11'd1024, 8'd255, 8'd0);
      send_pixel(11'd1024, 8'd255, 8'd255);
      send_pixel(11'd1400, 8'd1,   8'd1);

      // Phase one: the receiver stalls more than half the time.
      send_random_pixels(RANDOM_PIXELS_PER_PHASE);
      wait_for_drain();

      // Phase two: the sender is the slow side.
      send_idle_pct  = 55;
      recv_stall_pct = 18;
      send_random_pixels(RANDOM_PIXELS_PER_PHASE);
      wait_for_drain();

      // Phase three: neither side holds back, so beats go at full rate.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random_pixels(RANDOM_PIXELS_PER_PHASE);
      wait_for_drain();

      // Let any stray response beat show up before the verdict.
      repeat (12) @(negedge clock);

      $display("Checked %0d pixels across all six hue sectors, the wrapped hues and",
               pixels_checked);
      $display("both clamps, under three stall patterns; %0d mismatches.", mismatch_count);
      if (mismatch_count == 0 && pixels_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
